[hw/rtl/murmur64_key_hash_unit_macros.svh]
// ----------------------------------------------------------------------------
// murmur64_key_hash_unit_macros.svh
// Assertion macros shared by the key hash unit RTL.
// ----------------------------------------------------------------------------
`ifndef MURMUR64_KEY_HASH_UNIT_MACROS_SVH
`define MURMUR64_KEY_HASH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MKH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MKH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mkh_pkg.sv]
// ----------------------------------------------------------------------------
// mkh_pkg
// Types and constants shared by the key hash unit modules.
// ----------------------------------------------------------------------------
package mkh_pkg;

  localparam int WORD_W  = 64;
  localparam int LEN_W   = 32;
  localparam int BYTES_W = 4;
  localparam int SHIFT_W = 6;
  localparam int RSV_W   = 8;
  localparam int ADDR_W  = 5;

  // What the back end does with one word
  typedef enum logic [1:0] {
    OP_SKIP,
    OP_TAIL,
    OP_FULL
  } mkh_kind_t;

  // Configuration register indexes (byte address = 8 * index)
  typedef enum logic [1:0] {
    CFG_SEED,
    CFG_MULT,
    CFG_SHIFT,
    CFG_RSV
  } mkh_cfg_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_KEY_MIX,
    BK_KEY_FOLD,
    BK_HASH_MUL,
    BK_FINAL_MUL,
    BK_EMIT
  } mkh_state_t;

  // Classified word as it sits in the queue
  typedef struct packed {
    mkh_kind_t           kind;
    logic                first;
    logic                last;
    logic [WORD_W-1:0]   data;
    logic [WORD_W-1:0]   init;
  } mkh_op_t;

endpackage

[hw/rtl/mkh_mul.sv]
// ----------------------------------------------------------------------------
// mkh_mul
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module mkh_mul
  import mkh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] product
);

  logic [2*32-1:0] pp_ll;
  logic [31:0]     pp_lh;
  logic [31:0]     pp_hl;
  logic            stage1;

  // Partial products: the cross terms only feed the upper half
  always_ff @(posedge clk) begin
    pp_ll <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
    pp_lh <= a[31:0] * b[63:32];
    pp_hl <= a[63:32] * b[31:0];
  end

  // Sum held until the next start reaches the second stage
  always_ff @(posedge clk) begin
    if (stage1) begin
      product <= pp_ll + {pp_lh + pp_hl, 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

endmodule

[hw/rtl/mkh_front.sv]
// ----------------------------------------------------------------------------
// mkh_front
// Accepts key words, tracks key boundaries and classifies each word.
// ----------------------------------------------------------------------------
module mkh_front
  import mkh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [WORD_W-1:0]  key_word,
  input  logic [LEN_W-1:0]   key_length,
  input  logic [BYTES_W-1:0] word_bytes,
  input  logic               last_word,
  input  logic               key_valid,
  output logic               key_ready,
  input  logic [WORD_W-1:0]  seed,
  output mkh_op_t            op,
  output logic               op_valid,
  input  logic               op_ready
);

  logic              in_key;
  logic [WORD_W-1:0] tail_mask;

  // Byte lanes below the tail count stay
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (3'(i) < word_bytes[2:0]) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    op.first = !in_key;
    op.last  = last_word;
    op.init  = seed ^ {{(WORD_W-LEN_W){1'b0}}, key_length};
    if (word_bytes[3]) begin
      op.kind = OP_FULL;
      op.data = key_word;
    end else if (word_bytes[2:0] != 3'd0) begin
      op.kind = OP_TAIL;
      op.data = key_word & tail_mask;
    end else begin
      op.kind = OP_SKIP;
      op.data = key_word;
    end
  end

  assign op_valid  = key_valid;
  assign key_ready = op_ready;

  // Track whether the next beat opens a new key
  always_ff @(posedge clk) begin
    if (rst) begin
      in_key <= 1'b0;
    end else if (key_valid && op_ready) begin
      in_key <= !last_word;
    end
  end

endmodule

[hw/rtl/mkh_queue.sv]
// ----------------------------------------------------------------------------
// mkh_queue
// Small FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module mkh_queue
  import mkh_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  mkh_op_t push_data,
  output logic    not_full,
  input  logic    pop,
  output mkh_op_t pop_data,
  output logic    not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mkh_op_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && not_full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && not_full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/mkh_back.sv]
// ----------------------------------------------------------------------------
// mkh_back
// Runs the hash recurrence over queued words on a shared multiplier.
// ----------------------------------------------------------------------------
`include "murmur64_key_hash_unit_macros.svh"

module mkh_back
  import mkh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mkh_op_t            q_op,
  output logic               q_pop,
  input  logic [WORD_W-1:0]  multiplier,
  input  logic [SHIFT_W-1:0] shift_amount,
  input  logic [RSV_W-1:0]   reserved_max,
  output logic [WORD_W-1:0]  hash_value,
  output logic               hash_valid,
  input  logic               hash_ready
);

  localparam logic [WORD_W-1:0] HASH_BIAS = WORD_W'(2);

  mkh_state_t        state;
  mkh_state_t        state_next;
  logic [WORD_W-1:0] h;
  logic [WORD_W-1:0] h_next;
  logic              last_flag;
  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  logic              mul_done;
  logic [WORD_W-1:0] product;
  logic [WORD_W-1:0] h_base;
  logic [WORD_W-1:0] fin;
  logic [WORD_W-1:0] fin_adj;
  logic              emit;
  logic              mul_wait;
  logic              hash_stall;

  function automatic logic [WORD_W-1:0] xs(input logic [WORD_W-1:0] v,
                                           input logic [SHIFT_W-1:0] sh);
    return v ^ (v >> sh);
  endfunction

  mkh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (multiplier),
    .done    (mul_done),
    .product (product)
  );

  assign h_base  = q_op.first ? q_op.init : h;
  assign fin     = xs(product, shift_amount);
  assign fin_adj = (fin <= {{(WORD_W-RSV_W){1'b0}}, reserved_max}) ? fin + HASH_BIAS : fin;

  assign mul_wait   = (state == BK_KEY_MIX) || (state == BK_KEY_FOLD) ||
                      (state == BK_HASH_MUL) || (state == BK_FINAL_MUL);
  assign hash_stall = hash_valid && !hash_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_FULL: state_next = BK_KEY_MIX;
            OP_TAIL: state_next = BK_HASH_MUL;
            default: state_next = q_op.last ? BK_FINAL_MUL : BK_IDLE;
          endcase
        end
      end
      BK_KEY_MIX: begin
        if (mul_done) state_next = BK_KEY_FOLD;
      end
      BK_KEY_FOLD: begin
        if (mul_done) state_next = BK_HASH_MUL;
      end
      BK_HASH_MUL: begin
        if (mul_done) state_next = last_flag ? BK_FINAL_MUL : BK_IDLE;
      end
      BK_FINAL_MUL: begin
        if (mul_done) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!hash_valid || hash_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop     = 1'b0;
    mul_start = 1'b0;
    mul_a     = product;
    h_next    = h;
    emit      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          h_next = h_base;
          unique case (q_op.kind)
            OP_FULL: begin
              mul_start = 1'b1;
              mul_a     = q_op.data;
            end
            OP_TAIL: begin
              mul_start = 1'b1;
              mul_a     = h_base ^ q_op.data;
            end
            default: begin
              mul_start = q_op.last;
              mul_a     = xs(h_base, shift_amount);
            end
          endcase
        end
      end
      BK_KEY_MIX: begin
        mul_start = mul_done;
        mul_a     = xs(product, shift_amount);
      end
      BK_KEY_FOLD: begin
        mul_start = mul_done;
        mul_a     = h ^ product;
      end
      BK_HASH_MUL: begin
        mul_start = mul_done && last_flag;
        mul_a     = xs(product, shift_amount);
        if (mul_done && !last_flag) begin
          h_next = product;
        end
      end
      BK_EMIT: begin
        emit = !hash_valid || hash_ready;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    h <= h_next;
    if (q_pop) begin
      last_flag <= q_op.last;
    end
    if (emit) begin
      hash_value <= fin_adj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      hash_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        hash_valid <= 1'b1;
      end else if (hash_ready) begin
        hash_valid <= 1'b0;
      end
    end
  end

  `MKH_ASSERT_NXT(a_one_mul_in_flight, mul_start, !mul_start, "multiplier restarted early")
  `MKH_ASSERT_IMP(a_done_when_waiting, mul_done, mul_wait, "product arrived in no wait state")
  `MKH_ASSERT_NXT(a_hold_hash, hash_stall, hash_valid && $stable(hash_value), "held hash changed")

endmodule

[hw/rtl/murmur64_key_hash_unit.sv]
// ----------------------------------------------------------------------------
// murmur64_key_hash_unit
// MurmurHash64A-style hash of keys streamed as 64-bit little-endian words.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload                               beat
//  -------   ---------------------  ------------------------------------  ----------
//  key       key_valid/key_ready    key_word key_length word_bytes         one word
//                                   last_word
//  hash      hash_valid/hash_ready  hash_value                            one hash
//  config    psel/penable/pwrite    paddr pwdata prdata (pready tied 1)    one register
//
//  Sequencing: one two-stage multiplier, one multiply at a time; after
//  dispatch a full word takes three multiplies, a tail word one, an empty
//  word none. The last word adds the finalizer multiply and a load of the output register.
//  Reset: synchronous rst drops queue, key tracking, result; loads defaults.
//  Stalls: the front end keeps taking beats while the queue has room
//  (QUEUE_DEPTH words); a held result stalls only the back end.
//
//  Config map (64-bit registers, byte address 8 * index):
//    0 seed, 1 multiplier, 2 shift_amount [5:0], 3 reserved_max [7:0]
//
module murmur64_key_hash_unit
  import mkh_pkg::*;
#(
  // Queue depth between front and back, a power of two of at least 2
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic               clk,
  input  logic               rst,
  // key word channel
  input  logic [WORD_W-1:0]  key_word,
  input  logic [LEN_W-1:0]   key_length,
  input  logic [BYTES_W-1:0] word_bytes,
  input  logic               last_word,
  input  logic               key_valid,
  output logic               key_ready,
  // hash result channel
  output logic [WORD_W-1:0]  hash_value,
  output logic               hash_valid,
  input  logic               hash_ready,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready
);

  localparam logic [WORD_W-1:0] MULT_DEFAULT = 64'hc6a4a7935bd1e995;

  logic [WORD_W-1:0]  seed;
  logic [WORD_W-1:0]  multiplier;
  logic [SHIFT_W-1:0] shift_amount;
  logic [RSV_W-1:0]   reserved_max;
  mkh_cfg_t           cfg_sel;
  logic               cfg_write;

  mkh_op_t            front_op;
  logic               front_valid;
  logic               q_not_full;
  mkh_op_t            q_op;
  logic               q_not_empty;
  logic               q_pop;

  // Configuration registers: decode on the 8-byte word index
  assign pready    = 1'b1;
  assign cfg_sel   = mkh_cfg_t'(paddr[ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      multiplier   <= MULT_DEFAULT;
      shift_amount <= SHIFT_W'(47);
      reserved_max <= RSV_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_sel)
        CFG_SEED:  seed         <= pwdata;
        CFG_MULT:  multiplier   <= pwdata;
        CFG_SHIFT: shift_amount <= pwdata[SHIFT_W-1:0];
        CFG_RSV:   reserved_max <= pwdata[RSV_W-1:0];
        default:   seed         <= seed;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    unique case (cfg_sel)
      CFG_SEED:  prdata = seed;
      CFG_MULT:  prdata = multiplier;
      CFG_SHIFT: prdata = {{(WORD_W-SHIFT_W){1'b0}}, shift_amount};
      CFG_RSV:   prdata = {{(WORD_W-RSV_W){1'b0}}, reserved_max};
      default:   prdata = '0;
    endcase
  end

  // Front end: take the beat, tag first word, mask the tail
  mkh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key_word   (key_word),
    .key_length (key_length),
    .word_bytes (word_bytes),
    .last_word  (last_word),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .seed       (seed),
    .op         (front_op),
    .op_valid   (front_valid),
    .op_ready   (q_not_full)
  );

  // Decouple intake from the multiply loop
  mkh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_op),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .pop_data  (q_op),
    .not_empty (q_not_empty)
  );

  // Back end: mix, fold, finalize, hold the result for the sink
  mkh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .multiplier   (multiplier),
    .shift_amount (shift_amount),
    .reserved_max (reserved_max),
    .hash_value   (hash_value),
    .hash_valid   (hash_valid),
    .hash_ready   (hash_ready)
  );

endmodule
